[rtl/bhpm_pkg.sv]
// bhpm_pkg: shared constants, payload structs and control types of the
// bayer hot pixel median fix block; depends on nothing
package bhpm_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int RADIUS     = 2;
	localparam int REACH      = 2 * RADIUS;
	localparam int LEAD       = REACH + 1;
	localparam int SLOTS      = 4 * RADIUS + 2;
	localparam int SPAN       = 2 * RADIUS + 1;
	localparam int TAPS       = SPAN * SPAN;

	localparam int PIX_W  = 16;
	localparam int OUT_W  = 12;
	localparam int SHIFT  = 4;
	localparam int WID_W  = 12;
	localparam int HGT_W  = 13;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int SPAN_W = (SPAN > 1) ? $clog2(SPAN) : 1;
	localparam int TAP_W  = $clog2(TAPS + 1);
	localparam int ADDR_W = SLOT_W + COL_W;
	localparam int RAM_DEPTH = SLOTS * MAX_WIDTH;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic             opcode;
		logic [PIX_W-1:0] raw_pixel;
	} in_t;

	typedef struct packed {
		logic [OUT_W-1:0] corrected_pixel;
		logic             was_replaced;
		logic             frame_last;
	} out_t;

	typedef struct packed {
		logic [WID_W-1:0] width;
		logic [HGT_W-1:0] height;
		logic [PIX_W-1:0] thresh;
	} cfg_t;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} job_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

	typedef struct packed {
		logic             full;
		logic             empty;
		logic [ROW_W-1:0] head_row;
	} q_stat_t;

	typedef struct packed {
		logic             busy;
		logic [ROW_W-1:0] row;
	} bk_stat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CENTER,
		BK_SWEEP,
		BK_SHIFT,
		BK_FIN
	} bk_state_t;

	function automatic logic is_valid(input logic [PIX_W-1:0] v, input logic [PIX_W-1:0] thr);
		return (v != '0) && (v < thr);
	endfunction

endpackage

[rtl/bhpm_ram.sv]
// bhpm_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module bhpm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/bhpm_front.sv]
// bhpm_front: config registers, input/output position tracking, line store
// writes and job issue; depends on bhpm_pkg
module bhpm_front import bhpm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  in_t                   pix,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  q_stat_t               qs,
	input  bk_stat_t              bs,
	output logic                  push,
	output job_t                  job,
	output ram_wr_t               wr,
	output cfg_t                  cfg
);

	cfg_t              cfg_q;
	logic [ROW_W:0]    in_row_q;
	logic [COL_W-1:0]  in_col_q;
	logic [SLOT_W-1:0] in_slot_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              drain_q;
	logic              frame_end_q;

	logic              outstanding;
	logic [ROW_W-1:0]  oldest;
	logic              hold;
	logic              accept;
	logic              do_write;
	logic [COL_W:0]    col_inc;
	logic [ROW_W:0]    row_n;
	logic [COL_W:0]    col_n;
	logic [SLOT_W-1:0] slot_n;
	logic              drain_n;
	logic [ROW_W:0]    need_row;
	logic [COL_W:0]    need_col;
	logic              ready_out;
	logic              last;
	logic [COL_W:0]    out_col_inc;
	logic [WID_W-1:0]  w_clamp;
	logic [HGT_W-1:0]  h_clamp;
	logic              cfg_hit;

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

	assign cfg = cfg_q;

	always_comb begin
		outstanding = bs.busy || !qs.empty;
		oldest      = bs.busy ? bs.row : qs.head_row;
		hold        = outstanding &&
			(frame_end_q || (in_row_q > ({1'b0, oldest} + (ROW_W+1)'(LEAD))));
		pix_ready   = !qs.full && !hold;
		accept      = pix_valid && pix_ready;
		do_write    = accept && (pix.opcode == OP_PIXEL) && !drain_q;

		col_inc = {1'b0, in_col_q} + (COL_W+1)'(1);
		row_n   = in_row_q;
		col_n   = {1'b0, in_col_q};
		slot_n  = in_slot_q;
		drain_n = drain_q;
		if (do_write) begin
			if (col_inc >= cfg_q.width) begin
				col_n   = '0;
				row_n   = in_row_q + (ROW_W+1)'(1);
				slot_n  = slot_next(in_slot_q);
				drain_n = (row_n >= cfg_q.height);
			end else begin
				col_n = col_inc;
			end
		end

		need_row = {1'b0, out_row_q} + (ROW_W+1)'(REACH);
		if (need_row > cfg_q.height - HGT_W'(1)) begin
			need_row = cfg_q.height - HGT_W'(1);
		end
		need_col = {1'b0, out_col_q} + (COL_W+1)'(REACH);
		if (need_col > cfg_q.width - WID_W'(1)) begin
			need_col = cfg_q.width - WID_W'(1);
		end
		ready_out = drain_n || (row_n > need_row) || ((row_n == need_row) && (col_n > need_col));
		push      = accept && ready_out;

		last = ({1'b0, out_row_q} == cfg_q.height - HGT_W'(1)) &&
			({1'b0, out_col_q} == cfg_q.width - WID_W'(1));
		out_col_inc = {1'b0, out_col_q} + (COL_W+1)'(1);

		job.row  = out_row_q;
		job.col  = out_col_q;
		job.slot = out_slot_q;
		job.last = last;

		wr.en   = do_write;
		wr.addr = {in_slot_q, in_col_q};
		wr.data = pix.raw_pixel;

		w_clamp = cfg_data[WID_W-1:0];
		if (w_clamp == '0) begin
			w_clamp = WID_W'(1);
		end else if (w_clamp > WID_W'(MAX_WIDTH)) begin
			w_clamp = WID_W'(MAX_WIDTH);
		end
		h_clamp = cfg_data[HGT_W-1:0];
		if (h_clamp == '0) begin
			h_clamp = HGT_W'(1);
		end else if (h_clamp > HGT_W'(MAX_HEIGHT)) begin
			h_clamp = HGT_W'(MAX_HEIGHT);
		end
		cfg_hit = (cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT) ||
			(cfg_index == CFG_THRESH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= WID_W'(640);
			cfg_q.height <= HGT_W'(480);
			cfg_q.thresh <= PIX_W'(4096);
			in_row_q     <= '0;
			in_col_q     <= '0;
			in_slot_q    <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
			out_slot_q   <= '0;
			drain_q      <= 1'b0;
			frame_end_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH: begin
					cfg_q.width <= w_clamp;
				end
				CFG_HEIGHT: begin
					cfg_q.height <= h_clamp;
				end
				CFG_THRESH: begin
					cfg_q.thresh <= cfg_data[PIX_W-1:0];
				end
				default: begin
				end
			endcase
			if (cfg_hit) begin
				in_row_q    <= '0;
				in_col_q    <= '0;
				in_slot_q   <= '0;
				out_row_q   <= '0;
				out_col_q   <= '0;
				out_slot_q  <= '0;
				drain_q     <= 1'b0;
				frame_end_q <= 1'b0;
			end
		end else begin
			if (frame_end_q && !outstanding) begin
				frame_end_q <= 1'b0;
			end
			if (accept) begin
				if (push && last) begin
					in_row_q    <= '0;
					in_col_q    <= '0;
					in_slot_q   <= '0;
					out_row_q   <= '0;
					out_col_q   <= '0;
					out_slot_q  <= '0;
					drain_q     <= 1'b0;
					frame_end_q <= 1'b1;
				end else begin
					in_row_q  <= row_n;
					in_col_q  <= col_n[COL_W-1:0];
					in_slot_q <= slot_n;
					drain_q   <= drain_n;
					if (push) begin
						if (out_col_inc >= cfg_q.width) begin
							out_col_q  <= '0;
							out_row_q  <= out_row_q + ROW_W'(1);
							out_slot_q <= slot_next(out_slot_q);
						end else begin
							out_col_q <= out_col_inc[COL_W-1:0];
						end
					end
				end
			end
		end
	end

endmodule

[rtl/bhpm_queue.sv]
// bhpm_queue: short job queue between front and back
// depends on bhpm_pkg
module bhpm_queue import bhpm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	input  logic    pop,
	output job_t    head,
	output q_stat_t qs
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	always_comb begin
		head        = mem_q[rd_ptr_q];
		qs.full     = (cnt_q == (QPTR_W+1)'(QDEPTH));
		qs.empty    = (cnt_q == '0);
		qs.head_row = head.row;
		do_push     = push && !qs.full;
		do_pop      = pop && !qs.empty;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

[rtl/bhpm_back.sv]
// bhpm_back: center fetch, neighbour sweep, insertion sort and median output
// depends on bhpm_pkg; reads the line store through a ram read port
module bhpm_back import bhpm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  job_t             head,
	input  logic             q_empty,
	output logic             q_pop,
	output ram_rd_t          rd,
	input  logic [PIX_W-1:0] rdata,
	output logic             res_valid,
	input  logic             res_ready,
	output out_t             res,
	output bk_stat_t         bs
);

	localparam int SE_W = $clog2(3 * SLOTS);

	bk_state_t         state_q, state_n;
	job_t              job_s1;
	logic [TAP_W-1:0]  tcnt_q;
	logic [SPAN_W-1:0] dr_i_q;
	logic [SPAN_W-1:0] dc_i_q;
	logic              tap_v_s1;
	logic [PIX_W-1:0]  srt_q [TAPS];
	logic [TAP_W-1:0]  n_q;
	logic [TAP_W-1:0]  sh_q;
	logic              res_valid_q;
	out_t              res_q;

	logic              center_ok;
	logic              out_free;
	logic              tap_issue;
	logic              do_insert;
	logic              shift_done;
	logic [TAP_W-1:0]  half;
	logic              res_load;
	out_t              res_n;
	logic [ROW_W:0]    rr;
	logic [COL_W:0]    cc;
	logic [COL_W:0]    ccm;
	logic              in_frame;
	logic [SE_W-1:0]   st;
	logic              le [TAPS];
	logic [PIX_W-1:0]  ins [TAPS];
	logic [PIX_W:0]    pair_sum;
	logic [PIX_W-1:0]  med;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		center_ok = is_valid(rdata, cfg.thresh);
		out_free  = !res_valid_q || res_ready;
		half      = (n_q - TAP_W'(1)) >> 1;
		shift_done = (n_q == '0) || (sh_q == half);

		rr = {1'b0, job_s1.row} + ((ROW_W+1)'(dr_i_q) << 1);
		cc = {1'b0, job_s1.col} + ((COL_W+1)'(dc_i_q) << 1);
		ccm = cc - (COL_W+1)'(REACH);
		in_frame = (rr >= (ROW_W+1)'(REACH)) &&
			((rr - (ROW_W+1)'(REACH)) < cfg.height) &&
			(cc >= (COL_W+1)'(REACH)) && (ccm < cfg.width);
		st = SE_W'(job_s1.slot) + (SE_W'(dr_i_q) << 1) + SE_W'(SLOTS - REACH);
		if (st >= SE_W'(SLOTS)) begin
			st = st - SE_W'(SLOTS);
		end
		if (st >= SE_W'(SLOTS)) begin
			st = st - SE_W'(SLOTS);
		end

		for (int k = 0; k < TAPS; k++) begin
			le[k] = (TAP_W'(k) < n_q) && (srt_q[k] <= rdata);
		end
		ins[0] = le[0] ? srt_q[0] : rdata;
		for (int k = 1; k < TAPS; k++) begin
			if (le[k]) begin
				ins[k] = srt_q[k];
			end else if (le[k-1]) begin
				ins[k] = rdata;
			end else begin
				ins[k] = srt_q[k-1];
			end
		end

		pair_sum = {1'b0, srt_q[0]} + {1'b0, srt_q[1]};
		if (n_q == '0) begin
			med = '0;
		end else if (n_q[0]) begin
			med = srt_q[0];
		end else begin
			med = pair_sum[PIX_W:1];
		end

		bs.busy = (state_q != BK_IDLE);
		bs.row  = job_s1.row;
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					state_n = BK_CENTER;
				end
			end
			BK_CENTER: begin
				if (!center_ok) begin
					state_n = BK_SWEEP;
				end else if (out_free) begin
					state_n = q_empty ? BK_IDLE : BK_CENTER;
				end
			end
			BK_SWEEP: begin
				if (tcnt_q == TAP_W'(TAPS)) begin
					state_n = BK_SHIFT;
				end
			end
			BK_SHIFT: begin
				if (shift_done) begin
					state_n = BK_FIN;
				end
			end
			BK_FIN: begin
				if (out_free) begin
					state_n = BK_IDLE;
				end
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		q_pop     = 1'b0;
		tap_issue = 1'b0;
		do_insert = 1'b0;
		res_load  = 1'b0;
		res_n     = res_q;
		unique case (state_q)
			BK_IDLE: begin
				q_pop = !q_empty;
			end
			BK_CENTER: begin
				if (center_ok && out_free) begin
					q_pop    = !q_empty;
					res_load = 1'b1;
					res_n.corrected_pixel = rdata[PIX_W-1:SHIFT];
					res_n.was_replaced    = 1'b0;
					res_n.frame_last      = job_s1.last;
				end
			end
			BK_SWEEP: begin
				tap_issue = (tcnt_q < TAP_W'(TAPS));
				do_insert = tap_v_s1 && center_ok;
			end
			BK_SHIFT: begin
			end
			BK_FIN: begin
				if (out_free) begin
					res_load = 1'b1;
					res_n.corrected_pixel = med[PIX_W-1:SHIFT];
					res_n.was_replaced    = 1'b1;
					res_n.frame_last      = job_s1.last;
				end
			end
			default: begin
			end
		endcase
		rd.en   = q_pop || tap_issue;
		rd.addr = q_pop ? {head.slot, head.col} : {st[SLOT_W-1:0], ccm[COL_W-1:0]};
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_s1 <= head;
		end
		if (res_load) begin
			res_q <= res_n;
		end
		if (do_insert) begin
			for (int k = 0; k < TAPS; k++) begin
				srt_q[k] <= ins[k];
			end
		end else if (state_q == BK_SHIFT && !shift_done) begin
			for (int k = 0; k < TAPS - 1; k++) begin
				srt_q[k] <= srt_q[k+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			tcnt_q      <= '0;
			dr_i_q      <= '0;
			dc_i_q      <= '0;
			tap_v_s1    <= 1'b0;
			n_q         <= '0;
			sh_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == BK_CENTER && !center_ok) begin
				tcnt_q   <= '0;
				dr_i_q   <= '0;
				dc_i_q   <= '0;
				tap_v_s1 <= 1'b0;
				n_q      <= '0;
				sh_q     <= '0;
			end
			if (state_q == BK_SWEEP) begin
				tap_v_s1 <= tap_issue && in_frame;
				if (do_insert) begin
					n_q <= n_q + TAP_W'(1);
				end
				if (tap_issue) begin
					tcnt_q <= tcnt_q + TAP_W'(1);
					if (dc_i_q == SPAN_W'(SPAN - 1)) begin
						dc_i_q <= '0;
						dr_i_q <= dr_i_q + SPAN_W'(1);
					end else begin
						dc_i_q <= dc_i_q + SPAN_W'(1);
					end
				end
			end
			if (state_q == BK_SHIFT && !shift_done) begin
				sh_q <= sh_q + TAP_W'(1);
			end
		end
	end

endmodule

[rtl/bayer_hot_pixel_median_fix_top.sv]
// bayer_hot_pixel_median_fix_top: front, job queue, back and line store ram
// depends on bhpm_pkg, bhpm_front, bhpm_queue, bhpm_back, bhpm_ram
//
//  channel  handshake              payload
//  pix      pix_valid / pix_ready  pix (opcode, raw_pixel)
//  res      res_valid / res_ready  res (corrected_pixel, was_replaced, frame_last)
//  cfg      cfg_we                 cfg_index, cfg_data
//
// one request per cycle in while pix_ready is high; a valid pixel leaves through
// the center read of the line store, one per cycle back to back while jobs wait
// and the output is free; a replaced pixel holds the back for the center check,
// the 25 tap reads and the landing of the last tap, the median sorter shifts,
// the result load and the pop of the next job, longer while a result waits
// input stalls when the job queue is full, when the input row runs more than
// five rows past the oldest pending job row, and after a frame end until the
// back has drained; no clearing pass after reset
module bayer_hot_pixel_median_fix_top import bhpm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  in_t                   pix,
	output logic                  res_valid,
	input  logic                  res_ready,
	output out_t                  res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	q_stat_t          qs;
	bk_stat_t         bs;
	logic             push;
	job_t             push_job;
	job_t             head;
	logic             q_pop;
	ram_wr_t          wr;
	ram_rd_t          rd;
	cfg_t             cfg;
	logic [PIX_W-1:0] rdata;

	bhpm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.qs        (qs),
		.bs        (bs),
		.push      (push),
		.job       (push_job),
		.wr        (wr),
		.cfg       (cfg)
	);

	bhpm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (q_pop),
		.head     (head),
		.qs       (qs)
	);

	bhpm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head      (head),
		.q_empty   (qs.empty),
		.q_pop     (q_pop),
		.rd        (rd),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.bs        (bs)
	);

	bhpm_ram #(
		.WIDTH (PIX_W),
		.DEPTH (RAM_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd.en),
		.raddr (rd.addr),
		.rdata (rdata)
	);

endmodule
